@@ src/assert_macros.svh @@
// assertion macros shared by the pump health monitor rtl
// needs a clock named i_clk and an active-low reset named i_rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check on every clock edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// check on every clock edge, reset included
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

@@ src/psm_pkg.sv @@
// shared types, constants and helpers of the pump health score monitor
// no dependencies
package psm_pkg;

    // field widths
    localparam int unsigned SENS_W    = 16;
    localparam int unsigned GRADE_W   = 7;
    localparam int unsigned SCORE_W   = 14;
    localparam int unsigned LEVEL_W   = 3;
    localparam int unsigned RUN_W     = 15;
    localparam int unsigned EVT_W     = 16;
    localparam int unsigned PEN_W     = 25;
    localparam int unsigned PROD_W    = 23;
    localparam int unsigned CFG_IDX_W = 3;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TARGET    = 3'd0,
        CFG_TEMP_WARN = 3'd1,
        CFG_TEMP_CRIT = 3'd2,
        CFG_TEMP_STOP = 3'd3,
        CFG_AMP_WARN  = 3'd4,
        CFG_AMP_CRIT  = 3'd5
    } t_cfg_idx;

    // reset values of the configuration registers
    localparam logic signed [SENS_W-1:0] RST_TARGET    = -16'sd800;
    localparam logic signed [SENS_W-1:0] RST_TEMP_WARN = 16'sd600;
    localparam logic signed [SENS_W-1:0] RST_TEMP_CRIT = 16'sd700;
    localparam logic signed [SENS_W-1:0] RST_TEMP_STOP = 16'sd800;
    localparam logic [SENS_W-1:0]        RST_AMP_WARN  = 16'd4000;
    localparam logic [SENS_W-1:0]        RST_AMP_CRIT  = 16'd5000;

    // grade values in percent
    localparam logic [GRADE_W-1:0] GRADE_100 = 7'd100;
    localparam logic [GRADE_W-1:0] GRADE_90  = 7'd90;
    localparam logic [GRADE_W-1:0] GRADE_80  = 7'd80;
    localparam logic [GRADE_W-1:0] GRADE_70  = 7'd70;
    localparam logic [GRADE_W-1:0] GRADE_60  = 7'd60;
    localparam logic [GRADE_W-1:0] GRADE_50  = 7'd50;
    localparam logic [GRADE_W-1:0] GRADE_40  = 7'd40;

    // runtime limits
    localparam logic [RUN_W-1:0] RUN_MAX = 15'd20000;
    localparam logic [RUN_W-1:0] RUN_T1  = 15'd1000;
    localparam logic [RUN_W-1:0] RUN_T2  = 15'd5000;
    localparam logic [RUN_W-1:0] RUN_T3  = 15'd10000;

    // score weights and event penalties
    localparam logic [SCORE_W-1:0] W_PUMP    = 14'd35;
    localparam logic [SCORE_W-1:0] W_HEAT    = 14'd25;
    localparam logic [SCORE_W-1:0] W_AMP     = 14'd25;
    localparam logic [SCORE_W-1:0] W_AGE     = 14'd15;
    localparam logic [PEN_W-1:0]   PEN_HEAT  = 25'd200;
    localparam logic [PEN_W-1:0]   PEN_AMP   = 25'd150;
    localparam logic [SCORE_W-1:0] SCORE_MAX = 14'd10000;

    // maintenance level thresholds and codes
    localparam logic [SCORE_W-1:0] LVL_T_SOON   = 14'd9000;
    localparam logic [SCORE_W-1:0] LVL_T_RECOM  = 14'd7500;
    localparam logic [SCORE_W-1:0] LVL_T_URGENT = 14'd6000;
    localparam logic [SCORE_W-1:0] LVL_T_CRIT   = 14'd4500;
    localparam logic [LEVEL_W-1:0] MAINT_NONE   = 3'd0;
    localparam logic [LEVEL_W-1:0] MAINT_SOON   = 3'd1;
    localparam logic [LEVEL_W-1:0] MAINT_RECOM  = 3'd2;
    localparam logic [LEVEL_W-1:0] MAINT_URGENT = 3'd3;
    localparam logic [LEVEL_W-1:0] MAINT_CRIT   = 3'd4;

    // pressure ratio factors in percent
    localparam logic [PROD_W-1:0] PF_100 = 23'd100;
    localparam logic [PROD_W-1:0] PF_95  = 23'd95;
    localparam logic [PROD_W-1:0] PF_90  = 23'd90;
    localparam logic [PROD_W-1:0] PF_85  = 23'd85;
    localparam logic [PROD_W-1:0] PF_80  = 23'd80;
    localparam logic [PROD_W-1:0] PF_70  = 23'd70;

    // one input item
    typedef struct packed {
        logic                     action;
        logic signed [SENS_W-1:0] pressure;
        logic signed [SENS_W-1:0] temp;
        logic [SENS_W-1:0]        amps;
    } t_sample;

    // configuration registers
    typedef struct packed {
        logic signed [SENS_W-1:0] target;
        logic signed [SENS_W-1:0] temp_warn;
        logic signed [SENS_W-1:0] temp_crit;
        logic signed [SENS_W-1:0] temp_stop;
        logic [SENS_W-1:0]        amp_warn;
        logic [SENS_W-1:0]        amp_crit;
    } t_cfg;

    // grades of one sample
    typedef struct packed {
        logic [GRADE_W-1:0] pump;
        logic [GRADE_W-1:0] heat;
        logic [GRADE_W-1:0] amp;
        logic [GRADE_W-1:0] age;
    } t_grades;

    // event counter increments raised by one sample
    typedef struct packed {
        logic [1:0] heat_add;
        logic [1:0] amp_add;
    } t_evt;

    // one result item
    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic [LEVEL_W-1:0] level;
        t_grades            grades;
    } t_result;

    // saturating event counter add
    function automatic logic [EVT_W-1:0] sat_add(input logic [EVT_W-1:0] cnt,
                                                 input logic [1:0] by);
        logic [EVT_W:0] sum;
        sum = {1'b0, cnt} + {{(EVT_W-1){1'b0}}, by};
        return sum[EVT_W] ? {EVT_W{1'b1}} : sum[EVT_W-1:0];
    endfunction

endpackage

@@ src/psm_grade.sv @@
// grading of one sample: pump, heat, current and runtime grades and event increments
// depends on psm_pkg
module psm_grade (
    input  psm_pkg::t_sample                i_sample,
    input  psm_pkg::t_cfg                   i_cfg,
    input  logic [psm_pkg::RUN_W-1:0]       i_runtime,
    output psm_pkg::t_grades                o_grades,
    output psm_pkg::t_evt                   o_evt
);

    logic [psm_pkg::SENS_W-1:0]  w_abs_p;
    logic [psm_pkg::SENS_W-1:0]  w_abs_t;
    logic [psm_pkg::PROD_W-1:0]  w_p100;
    logic [psm_pkg::PROD_W-1:0]  w_t_ext;
    logic [psm_pkg::GRADE_W-1:0] w_pump;
    logic [psm_pkg::GRADE_W-1:0] w_heat;
    logic [psm_pkg::GRADE_W-1:0] w_amp;
    logic [psm_pkg::GRADE_W-1:0] w_age;
    logic [1:0]                  w_heat_add;
    logic [1:0]                  w_amp_add;

    // magnitudes, the most negative code maps to 32768 as unsigned
    assign w_abs_p = i_sample.pressure[psm_pkg::SENS_W-1] ?
                     psm_pkg::SENS_W'(-i_sample.pressure) : i_sample.pressure;
    assign w_abs_t = i_cfg.target[psm_pkg::SENS_W-1] ?
                     psm_pkg::SENS_W'(-i_cfg.target) : i_cfg.target;
    assign w_p100  = psm_pkg::PROD_W'(w_abs_p) * psm_pkg::PF_100;
    assign w_t_ext = psm_pkg::PROD_W'(w_abs_t);

    // pump grade by cross multiplication against the target
    always_comb begin
        priority if (i_cfg.target == '0)             w_pump = psm_pkg::GRADE_100;
        else if (w_p100 >= w_t_ext * psm_pkg::PF_95) w_pump = psm_pkg::GRADE_100;
        else if (w_p100 >= w_t_ext * psm_pkg::PF_90) w_pump = psm_pkg::GRADE_90;
        else if (w_p100 >= w_t_ext * psm_pkg::PF_85) w_pump = psm_pkg::GRADE_80;
        else if (w_p100 >= w_t_ext * psm_pkg::PF_80) w_pump = psm_pkg::GRADE_70;
        else if (w_p100 >= w_t_ext * psm_pkg::PF_70) w_pump = psm_pkg::GRADE_60;
        else                                         w_pump = psm_pkg::GRADE_50;
    end

    // heat grade, thresholds taken in order even when misordered
    always_comb begin
        priority if (i_sample.temp < i_cfg.temp_warn) begin
            w_heat     = psm_pkg::GRADE_100;
            w_heat_add = 2'd0;
        end else if (i_sample.temp < i_cfg.temp_crit) begin
            w_heat     = psm_pkg::GRADE_80;
            w_heat_add = 2'd1;
        end else if (i_sample.temp < i_cfg.temp_stop) begin
            w_heat     = psm_pkg::GRADE_60;
            w_heat_add = 2'd2;
        end else begin
            w_heat     = psm_pkg::GRADE_40;
            w_heat_add = 2'd3;
        end
    end

    // current grade
    always_comb begin
        priority if (i_sample.amps < i_cfg.amp_warn) begin
            w_amp     = psm_pkg::GRADE_100;
            w_amp_add = 2'd0;
        end else if (i_sample.amps < i_cfg.amp_crit) begin
            w_amp     = psm_pkg::GRADE_80;
            w_amp_add = 2'd1;
        end else begin
            w_amp     = psm_pkg::GRADE_60;
            w_amp_add = 2'd2;
        end
    end

    // runtime grade from the count before this sample
    always_comb begin
        priority if (i_runtime < psm_pkg::RUN_T1)   w_age = psm_pkg::GRADE_100;
        else if (i_runtime < psm_pkg::RUN_T2)       w_age = psm_pkg::GRADE_90;
        else if (i_runtime < psm_pkg::RUN_T3)       w_age = psm_pkg::GRADE_80;
        else if (i_runtime < psm_pkg::RUN_MAX)      w_age = psm_pkg::GRADE_70;
        else                                        w_age = psm_pkg::GRADE_60;
    end

    // gather the grades and increments
    assign o_grades = '{pump: w_pump, heat: w_heat, amp: w_amp, age: w_age};
    assign o_evt    = '{heat_add: w_heat_add, amp_add: w_amp_add};

endmodule

@@ src/psm_score.sv @@
// weighted score, event penalty with floor at zero, and maintenance level
// depends on psm_pkg
module psm_score (
    input  psm_pkg::t_grades                i_grades,
    input  logic [psm_pkg::EVT_W-1:0]       i_heat_events,
    input  logic [psm_pkg::EVT_W-1:0]       i_amp_events,
    output logic [psm_pkg::SCORE_W-1:0]     o_score,
    output logic [psm_pkg::LEVEL_W-1:0]     o_level
);

    logic [psm_pkg::SCORE_W-1:0] w_raw;
    logic [psm_pkg::PEN_W-1:0]   w_penalty;
    logic [psm_pkg::PEN_W-1:0]   w_raw_ext;

    // weighted sum of grades, at most 10000
    assign w_raw = psm_pkg::SCORE_W'(i_grades.pump) * psm_pkg::W_PUMP
                 + psm_pkg::SCORE_W'(i_grades.heat) * psm_pkg::W_HEAT
                 + psm_pkg::SCORE_W'(i_grades.amp)  * psm_pkg::W_AMP
                 + psm_pkg::SCORE_W'(i_grades.age)  * psm_pkg::W_AGE;

    // penalty from the updated event counters
    assign w_penalty = psm_pkg::PEN_W'(i_heat_events) * psm_pkg::PEN_HEAT
                     + psm_pkg::PEN_W'(i_amp_events)  * psm_pkg::PEN_AMP;
    assign w_raw_ext = psm_pkg::PEN_W'(w_raw);

    // floor at zero
    assign o_score = (w_penalty >= w_raw_ext) ? '0 :
                     psm_pkg::SCORE_W'(w_raw_ext - w_penalty);

    // maintenance level
    always_comb begin
        priority if (o_score >= psm_pkg::LVL_T_SOON)   o_level = psm_pkg::MAINT_NONE;
        else if (o_score >= psm_pkg::LVL_T_RECOM)      o_level = psm_pkg::MAINT_SOON;
        else if (o_score >= psm_pkg::LVL_T_URGENT)     o_level = psm_pkg::MAINT_RECOM;
        else if (o_score >= psm_pkg::LVL_T_CRIT)       o_level = psm_pkg::MAINT_URGENT;
        else                                           o_level = psm_pkg::MAINT_CRIT;
    end

endmodule

@@ src/pump_health_score_monitor.sv @@
// top level of the pump health score monitor: registers, counters, handshakes
// depends on psm_pkg, psm_grade, psm_score and assert_macros.svh
//
//  channel   direction  handshake                 payload
//  ------    ---------  ------------------------  ----------------------------------
//  in        input      i_in_valid / o_in_ready   i_action, i_pressure_in, i_temp_in,
//                                                 i_amps_in
//  out       output     o_out_valid / i_out_ready o_health_score, o_maint_level,
//                                                 o_pump_grade .. o_age_grade
//  cfg       input      i_cfg_we (no wait)        i_cfg_idx, i_cfg_data
//
// one item per cycle sustained while out is not stalled; an accepted item leaves
// through the input register, then the result register, grading and scoring between them
// counters and runtime update when an item moves into the result register
// a stalled result holds the result register; the input register still takes one
// more item, so ready falls only when both registers are full and out is stalled
// reset clears handshake state, counters, runtime and loads the threshold defaults
`include "assert_macros.svh"

module pump_health_score_monitor (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [psm_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [psm_pkg::SENS_W-1:0]          i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_action,
    input  logic signed [psm_pkg::SENS_W-1:0]   i_pressure_in,
    input  logic signed [psm_pkg::SENS_W-1:0]   i_temp_in,
    input  logic [psm_pkg::SENS_W-1:0]          i_amps_in,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [psm_pkg::SCORE_W-1:0]         o_health_score,
    output logic [psm_pkg::LEVEL_W-1:0]         o_maint_level,
    output logic [psm_pkg::GRADE_W-1:0]         o_pump_grade,
    output logic [psm_pkg::GRADE_W-1:0]         o_heat_grade,
    output logic [psm_pkg::GRADE_W-1:0]         o_amp_grade,
    output logic [psm_pkg::GRADE_W-1:0]         o_age_grade
);

    psm_pkg::t_cfg                  r_cfg;
    psm_pkg::t_sample               r_s1;
    logic                           r_s1_vld;
    psm_pkg::t_result               r_out;
    logic                           r_out_vld;
    logic [psm_pkg::RUN_W-1:0]      r_runtime;
    logic [psm_pkg::EVT_W-1:0]      r_heat_events;
    logic [psm_pkg::EVT_W-1:0]      r_amp_events;

    logic [psm_pkg::EVT_W-1:0]      n_heat_events;
    logic [psm_pkg::EVT_W-1:0]      n_amp_events;
    psm_pkg::t_result               n_out;

    logic                           w_move;
    psm_pkg::t_grades               w_grades;
    psm_pkg::t_evt                  w_evt;
    logic [psm_pkg::SCORE_W-1:0]    w_score;
    logic [psm_pkg::LEVEL_W-1:0]    w_level;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target    <= psm_pkg::RST_TARGET;
            r_cfg.temp_warn <= psm_pkg::RST_TEMP_WARN;
            r_cfg.temp_crit <= psm_pkg::RST_TEMP_CRIT;
            r_cfg.temp_stop <= psm_pkg::RST_TEMP_STOP;
            r_cfg.amp_warn  <= psm_pkg::RST_AMP_WARN;
            r_cfg.amp_crit  <= psm_pkg::RST_AMP_CRIT;
        end else if (i_cfg_we) begin
            case (psm_pkg::t_cfg_idx'(i_cfg_idx))
                psm_pkg::CFG_TARGET:    r_cfg.target    <= i_cfg_data;
                psm_pkg::CFG_TEMP_WARN: r_cfg.temp_warn <= i_cfg_data;
                psm_pkg::CFG_TEMP_CRIT: r_cfg.temp_crit <= i_cfg_data;
                psm_pkg::CFG_TEMP_STOP: r_cfg.temp_stop <= i_cfg_data;
                psm_pkg::CFG_AMP_WARN:  r_cfg.amp_warn  <= i_cfg_data;
                psm_pkg::CFG_AMP_CRIT:  r_cfg.amp_crit  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // handshake: the input register advances whenever the result register frees
    assign w_move     = r_s1_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_s1_vld || w_move;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_s1.action   <= i_action;
            r_s1.pressure <= i_pressure_in;
            r_s1.temp     <= i_temp_in;
            r_s1.amps     <= i_amps_in;
        end
    end

    // grading
    psm_grade u_grade (
        .i_sample (r_s1),
        .i_cfg    (r_cfg),
        .i_runtime(r_runtime),
        .o_grades (w_grades),
        .o_evt    (w_evt)
    );

    // counters after this item, cleared by a clear action
    assign n_heat_events = r_s1.action ? '0 : psm_pkg::sat_add(r_heat_events, w_evt.heat_add);
    assign n_amp_events  = r_s1.action ? '0 : psm_pkg::sat_add(r_amp_events, w_evt.amp_add);

    // scoring uses the counters after increment
    psm_score u_score (
        .i_grades     (w_grades),
        .i_heat_events(n_heat_events),
        .i_amp_events (n_amp_events),
        .o_score      (w_score),
        .o_level      (w_level)
    );

    // result selection, a clear gives full health
    always_comb begin
        if (r_s1.action) begin
            n_out.score       = psm_pkg::SCORE_MAX;
            n_out.level       = psm_pkg::MAINT_NONE;
            n_out.grades.pump = psm_pkg::GRADE_100;
            n_out.grades.heat = psm_pkg::GRADE_100;
            n_out.grades.amp  = psm_pkg::GRADE_100;
            n_out.grades.age  = psm_pkg::GRADE_100;
        end else begin
            n_out.score  = w_score;
            n_out.level  = w_level;
            n_out.grades = w_grades;
        end
    end

    // state update when an item moves on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_runtime     <= '0;
            r_heat_events <= '0;
            r_amp_events  <= '0;
        end else if (w_move) begin
            r_heat_events <= n_heat_events;
            r_amp_events  <= n_amp_events;
            if (!r_s1.action && (r_runtime < psm_pkg::RUN_MAX)) begin
                r_runtime <= r_runtime + 1'b1;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_move) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_move) begin
            r_out <= n_out;
        end
    end

    // outputs
    assign o_out_valid    = r_out_vld;
    assign o_health_score = r_out.score;
    assign o_maint_level  = r_out.level;
    assign o_pump_grade   = r_out.grades.pump;
    assign o_heat_grade   = r_out.grades.heat;
    assign o_amp_grade    = r_out.grades.amp;
    assign o_age_grade    = r_out.grades.age;

    // checks
    `ASSERT_CLK(a_runtime_sat, r_runtime <= psm_pkg::RUN_MAX, "runtime beyond saturation")
    `ASSERT_CLK(a_clear_zeroes, (w_move && r_s1.action) |=> (r_heat_events == '0 && r_amp_events == '0), "clear left counters set")
    `ASSERT_CLK(a_runtime_hold, !(w_move && !r_s1.action) |=> $stable(r_runtime), "runtime moved without an evaluated item")
    `ASSERT_CLK(a_score_range, r_out_vld |-> (r_out.score <= psm_pkg::SCORE_MAX), "score above full health")
    `ASSERT_ALWAYS(a_ready_free, !r_s1_vld |-> o_in_ready, "empty input register not ready")

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// testbench of the pump health score monitor: its own scoring model predicts every result item
// depends on psm_pkg and pump_health_score_monitor; stimulus, prediction and checks all live here

module tb;

    localparam int HALF_PERIOD  = 6;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 120;
    localparam int HOLD_AFTER   = 300;
    localparam int SOAK_ITEMS   = 100;
    localparam int EVT_SAT      = 65535;
    localparam int RUN_SAT      = 20000;

    // clock, reset and block inputs, all known from time zero
    logic                          i_clk          = 1'b0;
    logic                          i_rst_n        = 1'b0;
    logic                          i_cfg_we       = 1'b0;
    logic [psm_pkg::CFG_IDX_W-1:0] i_cfg_idx      = '0;
    logic [psm_pkg::SENS_W-1:0]    i_cfg_data     = '0;
    logic                          i_in_valid     = 1'b0;
    logic                          i_action       = 1'b0;
    logic [psm_pkg::SENS_W-1:0]    i_pressure_in  = '0;
    logic [psm_pkg::SENS_W-1:0]    i_temp_in      = '0;
    logic [psm_pkg::SENS_W-1:0]    i_amps_in      = '0;
    logic                          i_out_ready    = 1'b0;
    logic                          o_in_ready;
    logic                          o_out_valid;
    logic [psm_pkg::SCORE_W-1:0]   o_health_score;
    logic [psm_pkg::LEVEL_W-1:0]   o_maint_level;
    logic [psm_pkg::GRADE_W-1:0]   o_pump_grade;
    logic [psm_pkg::GRADE_W-1:0]   o_heat_grade;
    logic [psm_pkg::GRADE_W-1:0]   o_amp_grade;
    logic [psm_pkg::GRADE_W-1:0]   o_age_grade;

    // item stores and run bookkeeping
    psm_pkg::t_sample pending_samples[$];
    psm_pkg::t_result expected_results[$];
    psm_pkg::t_sample next_sample;
    psm_pkg::t_result got_result;
    psm_pkg::t_result want_result;
    int      mismatches   = 0;
    int      results_seen = 0;
    int      quiet_cycles = 0;
    int      hold_left    = 0;
    bit      hold_done    = 1'b0;
    bit      no_gaps      = 1'b0;

    // scoring model state: thresholds, runtime and event counters
    psm_pkg::t_cfg thr = '{target: psm_pkg::RST_TARGET, temp_warn: psm_pkg::RST_TEMP_WARN,
                           temp_crit: psm_pkg::RST_TEMP_CRIT, temp_stop: psm_pkg::RST_TEMP_STOP,
                           amp_warn: psm_pkg::RST_AMP_WARN, amp_crit: psm_pkg::RST_AMP_CRIT};
    int   run_cnt  = 0;
    int   heat_evt = 0;
    int   amp_evt  = 0;

    pump_health_score_monitor dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_action       (i_action),
        .i_pressure_in  (i_pressure_in),
        .i_temp_in      (i_temp_in),
        .i_amps_in      (i_amps_in),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_health_score (o_health_score),
        .o_maint_level  (o_maint_level),
        .o_pump_grade   (o_pump_grade),
        .o_heat_grade   (o_heat_grade),
        .o_amp_grade    (o_amp_grade),
        .o_age_grade    (o_age_grade)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // grade one sample and update runtime and event counters
    function automatic psm_pkg::t_result grade_sample(input psm_pkg::t_sample s);
        psm_pkg::t_result            r;
        logic [psm_pkg::GRADE_W-1:0] gp, gh, ga, gr;
        int                          p, t, ap, at, tc, add, score, penalty, a;
        if (s.action) begin
            heat_evt = 0;
            amp_evt  = 0;
            r.score  = psm_pkg::SCORE_MAX;
            r.level  = psm_pkg::MAINT_NONE;
            r.grades.pump = psm_pkg::GRADE_100;
            r.grades.heat = psm_pkg::GRADE_100;
            r.grades.amp  = psm_pkg::GRADE_100;
            r.grades.age  = psm_pkg::GRADE_100;
            return r;
        end
        // pump efficiency by cross multiplication of magnitudes
        p = int'(s.pressure);
        t = int'(thr.target);
        if (t == 0) begin
            gp = psm_pkg::GRADE_100;
        end else begin
            ap = (p < 0) ? -p : p;
            at = (t < 0) ? -t : t;
            ap = ap * 100;
            if (ap >= 95 * at)      gp = psm_pkg::GRADE_100;
            else if (ap >= 90 * at) gp = psm_pkg::GRADE_90;
            else if (ap >= 85 * at) gp = psm_pkg::GRADE_80;
            else if (ap >= 80 * at) gp = psm_pkg::GRADE_70;
            else if (ap >= 70 * at) gp = psm_pkg::GRADE_60;
            else                    gp = psm_pkg::GRADE_50;
        end
        // temperature, thresholds taken in order even when misordered
        tc = int'(s.temp);
        if (tc < int'(thr.temp_warn)) begin
            gh = psm_pkg::GRADE_100; add = 0;
        end else if (tc < int'(thr.temp_crit)) begin
            gh = psm_pkg::GRADE_80; add = 1;
        end else if (tc < int'(thr.temp_stop)) begin
            gh = psm_pkg::GRADE_60; add = 2;
        end else begin
            gh = psm_pkg::GRADE_40; add = 3;
        end
        heat_evt = (heat_evt + add > EVT_SAT) ? EVT_SAT : heat_evt + add;
        // current
        a = int'(s.amps);
        if (a < int'(thr.amp_warn)) begin
            ga = psm_pkg::GRADE_100; add = 0;
        end else if (a < int'(thr.amp_crit)) begin
            ga = psm_pkg::GRADE_80; add = 1;
        end else begin
            ga = psm_pkg::GRADE_60; add = 2;
        end
        amp_evt = (amp_evt + add > EVT_SAT) ? EVT_SAT : amp_evt + add;
        // runtime before this sample
        if (run_cnt < int'(psm_pkg::RUN_T1))       gr = psm_pkg::GRADE_100;
        else if (run_cnt < int'(psm_pkg::RUN_T2))  gr = psm_pkg::GRADE_90;
        else if (run_cnt < int'(psm_pkg::RUN_T3))  gr = psm_pkg::GRADE_80;
        else if (run_cnt < int'(psm_pkg::RUN_MAX)) gr = psm_pkg::GRADE_70;
        else                                       gr = psm_pkg::GRADE_60;
        // weighted score less the event penalty, floored at zero
        score   = int'(gp) * 35 + int'(gh) * 25 + int'(ga) * 25 + int'(gr) * 15;
        penalty = heat_evt * 200 + amp_evt * 150;
        score   = (penalty >= score) ? 0 : score - penalty;
        r.score = psm_pkg::SCORE_W'(score);
        if (score >= int'(psm_pkg::LVL_T_SOON))        r.level = psm_pkg::MAINT_NONE;
        else if (score >= int'(psm_pkg::LVL_T_RECOM))  r.level = psm_pkg::MAINT_SOON;
        else if (score >= int'(psm_pkg::LVL_T_URGENT)) r.level = psm_pkg::MAINT_RECOM;
        else if (score >= int'(psm_pkg::LVL_T_CRIT))   r.level = psm_pkg::MAINT_URGENT;
        else                                           r.level = psm_pkg::MAINT_CRIT;
        r.grades.pump = gp;
        r.grades.heat = gh;
        r.grades.amp  = ga;
        r.grades.age  = gr;
        if (run_cnt < RUN_SAT) run_cnt++;
        return r;
    endfunction

    function automatic logic [psm_pkg::SENS_W-1:0] clamp_s16(input int v);
        if (v > 32767) return 16'h7fff;
        if (v < -32768) return 16'h8000;
        return v[psm_pkg::SENS_W-1:0];
    endfunction

    function automatic logic [psm_pkg::SENS_W-1:0] clamp_u16(input int v);
        if (v > 65535) return 16'hffff;
        if (v < 0) return 16'h0000;
        return v[psm_pkg::SENS_W-1:0];
    endfunction

    function automatic psm_pkg::t_cfg make_cfg(input int tg, input int tw, input int tc,
                                               input int ts, input int aw, input int ac);
        psm_pkg::t_cfg c;
        c.target    = tg[psm_pkg::SENS_W-1:0];
        c.temp_warn = tw[psm_pkg::SENS_W-1:0];
        c.temp_crit = tc[psm_pkg::SENS_W-1:0];
        c.temp_stop = ts[psm_pkg::SENS_W-1:0];
        c.amp_warn  = aw[psm_pkg::SENS_W-1:0];
        c.amp_crit  = ac[psm_pkg::SENS_W-1:0];
        return c;
    endfunction

    // random thresholds, mostly in order, sometimes left misordered
    function automatic psm_pkg::t_cfg rand_cfg();
        int a, b, c, tmp, w, k;
        a = int'($urandom_range(65535)) - 32768;
        b = int'($urandom_range(65535)) - 32768;
        c = int'($urandom_range(65535)) - 32768;
        w = int'($urandom_range(65535));
        k = int'($urandom_range(65535));
        if ($urandom_range(3) != 0) begin
            if (a > b) begin tmp = a; a = b; b = tmp; end
            if (b > c) begin tmp = b; b = c; c = tmp; end
            if (a > b) begin tmp = a; a = b; b = tmp; end
            if (w > k) begin tmp = w; w = k; k = tmp; end
        end
        return make_cfg(int'($urandom_range(65535)) - 32768, a, b, c, w, k);
    endfunction

    // random sample, steered towards grade boundaries of the current thresholds
    function automatic psm_pkg::t_sample rand_sample();
        psm_pkg::t_sample s;
        int               at, v, d;
        s.action = ($urandom_range(99) < 6);
        d = int'($urandom_range(4));
        at = int'(thr.target);
        at = (at < 0) ? -at : at;
        case ($urandom_range(3))
            0, 1: begin
                v = at * int'($urandom_range(60, 105)) / 100 + d - 2;
                if ($urandom_range(1)) v = -v;
                s.pressure = clamp_s16(v);
            end
            2: s.pressure = psm_pkg::SENS_W'($urandom_range(65535));
            default: s.pressure = clamp_s16(($urandom_range(1) ? at : -at) + d - 2);
        endcase
        case ($urandom_range(4))
            0: s.temp = clamp_s16(int'(thr.temp_warn) + d - 2);
            1: s.temp = clamp_s16(int'(thr.temp_crit) + d - 2);
            2: s.temp = clamp_s16(int'(thr.temp_stop) + d - 2);
            default: s.temp = psm_pkg::SENS_W'($urandom_range(65535));
        endcase
        d = int'($urandom_range(4));
        case ($urandom_range(3))
            0: s.amps = clamp_u16(int'(thr.amp_warn) + d - 2);
            1: s.amps = clamp_u16(int'(thr.amp_crit) + d - 2);
            default: s.amps = psm_pkg::SENS_W'($urandom_range(65535));
        endcase
        return s;
    endfunction

    task automatic push_sample(input bit act, input int p, input int t, input int a);
        psm_pkg::t_sample s;
        s.action   = act;
        s.pressure = p[psm_pkg::SENS_W-1:0];
        s.temp     = t[psm_pkg::SENS_W-1:0];
        s.amps     = a[psm_pkg::SENS_W-1:0];
        pending_samples.push_back(s);
    endtask

    // wait until every item has gone through and its result has been checked
    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_samples.size() != 0 || expected_results.size() != 0 || i_in_valid);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // write all six thresholds back to back while the block is idle
    task automatic apply_config(input psm_pkg::t_cfg c);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= psm_pkg::CFG_TARGET;
        i_cfg_data <= c.target;
        @(posedge i_clk);
        i_cfg_idx  <= psm_pkg::CFG_TEMP_WARN;
        i_cfg_data <= c.temp_warn;
        @(posedge i_clk);
        i_cfg_idx  <= psm_pkg::CFG_TEMP_CRIT;
        i_cfg_data <= c.temp_crit;
        @(posedge i_clk);
        i_cfg_idx  <= psm_pkg::CFG_TEMP_STOP;
        i_cfg_data <= c.temp_stop;
        @(posedge i_clk);
        i_cfg_idx  <= psm_pkg::CFG_AMP_WARN;
        i_cfg_data <= c.amp_warn;
        @(posedge i_clk);
        i_cfg_idx  <= psm_pkg::CFG_AMP_CRIT;
        i_cfg_data <= c.amp_crit;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        thr = c;
        @(negedge i_clk);
    endtask

    task automatic run_random(input int n, input bit calm);
        no_gaps = calm;
        repeat (n) pending_samples.push_back(rand_sample());
        wait_drained();
        no_gaps = 1'b0;
    endtask

    // run of random samples: under worst-grade thresholds events pile up and hold the score at its floor
    task automatic run_soak();
        psm_pkg::t_sample s;
        repeat (SOAK_ITEMS) begin
            s.action   = 1'b0;
            s.pressure = psm_pkg::SENS_W'($urandom_range(65535));
            s.temp     = psm_pkg::SENS_W'($urandom_range(65535));
            s.amps     = psm_pkg::SENS_W'($urandom_range(65535));
            pending_samples.push_back(s);
        end
        wait_drained();
    endtask

    // sender: offers queued items, holds valid and payload until accepted
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready)
                expected_results.push_back(grade_sample({i_action, i_pressure_in,
                                                         i_temp_in, i_amps_in}));
            if (!i_in_valid || o_in_ready) begin
                if (pending_samples.size() != 0 &&
                    (no_gaps || hold_left != 0 || $urandom_range(99) >= 32)) begin
                    next_sample   = pending_samples.pop_front();
                    i_in_valid    <= 1'b1;
                    i_action      <= next_sample.action;
                    i_pressure_in <= next_sample.pressure;
                    i_temp_in     <= next_sample.temp;
                    i_amps_in     <= next_sample.amps;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: checks each result item against the oldest prediction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                results_seen++;
                got_result = {o_health_score, o_maint_level, o_pump_grade, o_heat_grade,
                              o_amp_grade, o_age_grade};
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d arrived with nothing expected", results_seen);
                end else begin
                    want_result = expected_results.pop_front();
                    if (got_result.score !== want_result.score ||
                        got_result.level !== want_result.level ||
                        got_result.grades.pump !== want_result.grades.pump ||
                        got_result.grades.heat !== want_result.grades.heat ||
                        got_result.grades.amp !== want_result.grades.amp ||
                        got_result.grades.age !== want_result.grades.age) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"result %0d: expected score %0d level %0d ",
                                      "grades %0d %0d %0d %0d, got score %0d level %0d ",
                                      "grades %0d %0d %0d %0d"},
                                     results_seen, want_result.score, want_result.level,
                                     want_result.grades.pump, want_result.grades.heat,
                                     want_result.grades.amp, want_result.grades.age,
                                     got_result.score, got_result.level,
                                     got_result.grades.pump, got_result.grades.heat,
                                     got_result.grades.amp, got_result.grades.age);
                    end
                end
            end
            // one long hold-off so the block fills and stalls its input
            if (hold_left != 0) begin
                hold_left   <= hold_left - 1;
                i_out_ready <= 1'b0;
            end else if (!hold_done && results_seen >= HOLD_AFTER) begin
                hold_left   <= HOLD_CYCLES;
                hold_done   <= 1'b1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= no_gaps || ($urandom_range(99) >= 32);
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // stimulus phases
    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset thresholds: every pump, heat and current boundary, extremes, clears
        push_sample(1'b0,   -800,      0,     0);
        push_sample(1'b0,   -760,    599,  3999);
        push_sample(1'b0,   -759,    600,  4000);
        push_sample(1'b0,   -720,    699,  4999);
        push_sample(1'b0,   -680,    700,  5000);
        push_sample(1'b0,   -640,    799, 65535);
        push_sample(1'b0,   -560,    800,     0);
        push_sample(1'b0,   -559,  32767,     0);
        push_sample(1'b0,  32767, -32768, 65535);
        push_sample(1'b0, -32768,      0,     0);
        push_sample(1'b0,      0,      0,     0);
        push_sample(1'b1, -32768,  32767, 65535);
        push_sample(1'b0,   -800,      0,     0);
        push_sample(1'b1,      0,      0,     0);
        wait_drained();

        // zero target and misordered thresholds
        apply_config(make_cfg(0, 500, 300, 100, 6000, 2000));
        push_sample(1'b0,  123, 499, 5999);
        push_sample(1'b0,   -5, 500, 6000);
        run_random(200, 1'b0);

        // extreme thresholds, run with no random idling on either side; the long receiver hold-off falls in this run
        apply_config(make_cfg(-32768, -32768, 0, 32767, 0, 65535));
        push_sample(1'b0, -32768, -32768,     0);
        push_sample(1'b0,      0,  32767, 65535);
        push_sample(1'b0,  32767,     -1, 65534);
        run_random(220, 1'b1);

        apply_config(make_cfg(32767, 32767, 32767, 32767, 65535, 65535));
        run_random(200, 1'b0);

        repeat (3) begin
            apply_config(rand_cfg());
            run_random(180, 1'b0);
        end

        // heat and current at their worst grades so events pile up and the score sits at zero
        apply_config(make_cfg(int'($urandom_range(65535)) - 32768,
                              -32768, -32768, -32768, 0, 0));
        run_soak();

        // back to the reset thresholds after the worst-grade run
        apply_config(make_cfg(-800, 600, 700, 800, 4000, 5000));
        push_sample(1'b1, 0, 0, 0);
        run_random(100, 1'b0);

        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
